@@ rtl/wast_pkg.sv @@
`default_nettype none
package wast_pkg;
    localparam int ANGLE_W  = 24;
    localparam int DIVD_W   = 40;
    localparam int REM_W    = 24;
    localparam int DIVS_W   = 23;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEGREES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_FACT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 3'd4;

    localparam logic [14:0] MAX_DEG_RESET = 15'd900;
    localparam logic [15:0] GAIN_RESET    = 16'd256;
    localparam logic [15:0] PFACT_RESET   = 16'd256;
    localparam logic [13:0] PLIMIT_RESET  = 14'd10000;
    localparam logic [14:0] LOCK_BOUND    = 15'h7FFF;

    typedef struct packed {
        logic start;
        logic div_step;
        logic mul1;
        logic mul2;
        logic mul3;
        logic mul4;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

@@ rtl/wast_ctrl.sv @@
`default_nettype none
module wast_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wast_pkg::t_status   i_status,
    output wast_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_MUL3 = 3'd4;
    localparam logic [2:0] S_MUL4 = 3'd5;
    localparam logic [2:0] S_LOAD = 3'd6;

    logic [2:0] r_state, n_state;
    logic [wast_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == wast_pkg::CNT_W'(wast_pkg::DIV_STEPS - 1)) n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_MUL4;
            end
            S_MUL4: begin
                o_cmd.mul4 = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

@@ rtl/wast_dp.sv @@
`default_nettype none
module wast_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wast_pkg::t_cmd                       i_cmd,
    output wast_pkg::t_status                    o_status,
    input  wire                                  i_cfg_valid,
    input  wire  [wast_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [wast_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  wire  signed [wast_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [31:0]                   o_position,
    output logic signed [15:0]                   o_axis_report,
    output logic signed [34:0]                   o_velocity,
    output logic signed [44:0]                   o_acceleration,
    output logic signed [15:0]                   o_lock_torque,
    output logic signed [14:0]                   o_drive_torque,
    output logic                                 o_torque_changed
);
    localparam int RQ_W = wast_pkg::REM_W + wast_pkg::DIVD_W;

    logic [14:0] r_maxdeg;
    logic [7:0]  r_strength;
    logic [15:0] r_gain, r_pfact;
    logic [13:0] r_plim;

    logic signed [23:0] r_last_angle, r_angle;
    logic signed [34:0] r_last_vel, r_vel;
    logic signed [24:0] r_last_raw, r_raw;
    logic signed [44:0] r_acc;
    logic signed [31:0] r_pos;
    logic               r_neg, r_dir_pos, r_dir_neg;
    logic [RQ_W-1:0]    r_rq;
    logic [31:0]        r_es;
    logic [14:0]        r_mag;
    logic signed [15:0] r_lock;
    logic               r_out_valid;

    // dividend magnitude 65535*|a| and divisor 256*m
    logic [23:0] w_abs;
    logic [39:0] w_dividend;
    logic [wast_pkg::DIVS_W-1:0] w_divisor;
    assign w_abs      = i_angle[23] ? 24'(-i_angle) : 24'(i_angle);
    assign w_dividend = ({16'd0, w_abs} << 16) - {16'd0, w_abs};
    assign w_divisor  = {r_maxdeg, 8'd0};

    logic [RQ_W-1:0] w_sh, w_rq_next;
    logic [23:0]     w_top;
    always_comb begin
        w_sh      = {r_rq[RQ_W-2:0], 1'b0};
        w_top     = w_sh[RQ_W-1:wast_pkg::DIVD_W];
        w_rq_next = w_sh;
        if (w_top >= {1'b0, w_divisor}) begin
            w_rq_next[RQ_W-1:wast_pkg::DIVD_W] = w_top - {1'b0, w_divisor};
            w_rq_next[0] = 1'b1;
        end
    end

    // x*1000 as shifts
    logic signed [24:0] w_dang;
    logic signed [34:0] w_vel;
    logic signed [35:0] w_dvel;
    logic signed [45:0] w_acc_full;
    assign w_dang     = {r_angle[23], r_angle} - {r_last_angle[23], r_last_angle};
    assign w_vel      = (35'(w_dang) <<< 10) - (35'(w_dang) <<< 4) - (35'(w_dang) <<< 3);
    assign w_dvel     = {r_vel[34], r_vel} - {r_last_vel[34], r_last_vel};
    assign w_acc_full = (46'(w_dvel) <<< 10) - (46'(w_dvel) <<< 4) - (46'(w_dvel) <<< 3);

    logic [31:0] w_q;
    assign w_q = r_rq[31:0];

    // overshoot, positive whenever a direction is set
    logic signed [25:0] w_e;
    logic               w_dpos, w_dneg;
    assign w_dpos = (r_pos > 32'sd32767);
    assign w_dneg = (r_pos < -32'sd32767);
    assign w_e = (w_dpos ? 26'(r_angle) : -26'(r_angle)) - 26'({r_maxdeg, 7'd0});

    logic [47:0] w_esg;
    logic [30:0] w_mp;
    assign w_esg = r_es * r_gain;
    assign w_mp  = r_mag * r_pfact;

    logic signed [24:0] w_lim, w_drive;
    always_comb begin
        w_lim = 25'(r_plim);
        if (r_raw > w_lim)       w_drive = w_lim;
        else if (r_raw < -w_lim) w_drive = -w_lim;
        else                     w_drive = r_raw;
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxdeg     <= wast_pkg::MAX_DEG_RESET;
            r_strength   <= '0;
            r_gain       <= wast_pkg::GAIN_RESET;
            r_pfact      <= wast_pkg::PFACT_RESET;
            r_plim       <= wast_pkg::PLIMIT_RESET;
            r_last_angle <= '0;
            r_last_vel   <= '0;
            r_last_raw   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    wast_pkg::REG_MAX_DEGREES: if (i_cfg_data[14:0] != '0) begin
                        r_maxdeg <= i_cfg_data[14:0];
                    end
                    wast_pkg::REG_STRENGTH:    r_strength <= i_cfg_data[7:0];
                    wast_pkg::REG_GAIN:        r_gain     <= i_cfg_data;
                    wast_pkg::REG_POWER_FACT:  r_pfact    <= i_cfg_data;
                    wast_pkg::REG_POWER_LIMIT: r_plim     <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_out_valid  <= 1'b1;
                r_last_angle <= r_angle;
                r_last_vel   <= r_vel;
                r_last_raw   <= r_raw;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_angle <= i_angle;
            r_neg   <= i_angle[23];
            r_rq    <= {{wast_pkg::REM_W{1'b0}}, w_dividend};
        end
        if (i_cmd.div_step) r_rq <= w_rq_next;
        if (i_cmd.mul1) begin
            r_pos <= r_neg ? -$signed(w_q) : $signed(w_q);
            r_vel <= w_vel;
        end
        if (i_cmd.mul2) begin
            r_dir_pos <= w_dpos;
            r_dir_neg <= w_dneg;
            r_es      <= 32'(w_e[23:0]) * 32'(r_strength);
            if (w_acc_full > 46'sh0FFFFFFFFFFF)       r_acc <= 45'h0FFFFFFFFFFF;
            else if (w_acc_full < -46'sh100000000000) r_acc <= 45'h100000000000;
            else                                      r_acc <= 45'(w_acc_full);
        end
        if (i_cmd.mul3) begin
            if (!(r_dir_pos || r_dir_neg))       r_mag <= '0;
            else if (w_esg[47:16] > 32'h7FFF)    r_mag <= wast_pkg::LOCK_BOUND;
            else                                 r_mag <= w_esg[30:16];
        end
        if (i_cmd.mul4) begin
            r_lock <= r_dir_pos ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            r_raw  <= r_dir_pos ? -$signed({1'b0, w_mp[30:8]}) : $signed({1'b0, w_mp[30:8]});
        end
        if (i_cmd.load) begin
            o_position       <= r_pos;
            o_axis_report    <= r_pos[15:0];
            o_velocity       <= r_vel;
            o_acceleration   <= r_acc;
            o_lock_torque    <= r_lock;
            o_drive_torque   <= w_drive[14:0];
            o_torque_changed <= (r_raw != r_last_raw);
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> o_status.out_free)
        else $error("result load while output register busy");
    a_drive_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (o_drive_torque <= $signed({1'b0, $past(r_plim)}))
                    && (o_drive_torque >= -$signed({1'b0, $past(r_plim)})))
        else $error("drive torque beyond power limit");
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.mul2) |-> !(r_dir_pos && r_dir_neg))
        else $error("both lock directions set");
endmodule
`default_nettype wire

@@ rtl/wheel_axis_softlock_torque_unit.sv @@
`default_nettype none
// soft-lock torque unit for a force feedback wheel axis. each angle sample
// transfer yields one result transfer: scaled position and report axis,
// velocity and acceleration (differences times 1000), soft-lock torque and
// drive torque with a change flag. each sample passes through the 40-step
// bit-serial divider for the position scaling, four multiply stages and the
// load, which waits while the output register still holds an untaken result;
// input ready is high only while the sequencer is idle.
// the result sits in an output register, so the next sample is taken while a
// result waits. configuration writes are always ready and should happen only
// while the unit is idle.
module wheel_axis_softlock_torque_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [wast_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [wast_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // sample input
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [wast_pkg::ANGLE_W-1:0]  i_angle,
    // result output
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [31:0]                   o_position,
    output logic signed [15:0]                   o_axis_report,
    output logic signed [34:0]                   o_velocity,
    output logic signed [44:0]                   o_acceleration,
    output logic signed [15:0]                   o_lock_torque,
    output logic signed [14:0]                   o_drive_torque,
    output logic                                 o_torque_changed
);
    wast_pkg::t_cmd    w_cmd;
    wast_pkg::t_status w_status;

    // register writes are always accepted
    assign o_cfg_ready = 1'b1;

    // sequencer: start, divide, multiply stages, load
    wast_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic, state and output register
    wast_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_angle          (i_angle),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_position       (o_position),
        .o_axis_report    (o_axis_report),
        .o_velocity       (o_velocity),
        .o_acceleration   (o_acceleration),
        .o_lock_torque    (o_lock_torque),
        .o_drive_torque   (o_drive_torque),
        .o_torque_changed (o_torque_changed)
    );
endmodule
`default_nettype wire

@@ tb/wheel_axis_softlock_torque_unit_test.sv @@
`timescale 1ns / 1ps
module wheel_axis_softlock_torque_unit_test;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    // index that maps to no register
    localparam logic [wast_pkg::CFG_IDX_W-1:0] UNUSED_REG = 3'd7;

    // the result one angle sample should produce
    typedef struct {
        logic signed [31:0] position;
        logic signed [15:0] axis_report;
        logic signed [34:0] velocity;
        logic signed [44:0] acceleration;
        logic signed [15:0] lock_torque;
        logic signed [14:0] drive_torque;
        logic               torque_changed;
    } t_wheel_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [wast_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [wast_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [wast_pkg::ANGLE_W-1:0] i_angle = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_torque_changed;
    logic signed [31:0] o_position;
    logic signed [15:0] o_axis_report, o_lock_torque;
    logic signed [34:0] o_velocity;
    logic signed [44:0] o_acceleration;
    logic signed [14:0] o_drive_torque;

    wheel_axis_softlock_torque_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor copy of the registers and history
    longint unsigned deg_range = 900;
    longint unsigned lock_strength = 0;
    longint unsigned lock_gain = 256;
    longint unsigned pwr_factor = 256;
    longint unsigned pwr_limit = 10000;
    longint prev_angle = 0, prev_velocity = 0, prev_raw = 0;

    logic signed [wast_pkg::ANGLE_W-1:0] angle_queue[$];
    t_wheel_result expected_results[$];
    int unsigned mismatches = 0;
    int unsigned samples_sent = 0, results_seen = 0;
    int unsigned idle_pct = 0, stall_pct = 0;
    int unsigned quiet_cycles = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // mirror of a register write, zero range writes are dropped
    function automatic void shadow_write(logic [wast_pkg::CFG_IDX_W-1:0] idx,
                                         logic [wast_pkg::CFG_DAT_W-1:0] d);
        case (idx)
            wast_pkg::REG_MAX_DEGREES: if (d[14:0] != 0) deg_range = d[14:0];
            wast_pkg::REG_STRENGTH:    lock_strength = d[7:0];
            wast_pkg::REG_GAIN:        lock_gain = d;
            wast_pkg::REG_POWER_FACT:  pwr_factor = d;
            wast_pkg::REG_POWER_LIMIT: pwr_limit = d[13:0];
            default: ;
        endcase
    endfunction

    function automatic t_wheel_result predict_torque(
        logic signed [wast_pkg::ANGLE_W-1:0] angle);
        t_wheel_result r;
        longint a, m, pos, vel, acc, e, mag, lock, raw;
        a = angle;
        m = deg_range;
        // signed longint division truncates toward zero
        pos = clip((65535 * a) / (256 * m), -64'sd2147483648, 64'sd2147483647);
        vel = (a - prev_angle) * 1000;
        acc = clip((vel - prev_velocity) * 1000, -64'sd17592186044416, 64'sd17592186044415);
        lock = 0;
        if (pos > 32767 || pos < -32767) begin
            e = (pos > 0 ? a : -a) - 128 * m;
            mag = clip((e * longint'(lock_strength) * longint'(lock_gain)) / 65536,
                       -32767, 32767);
            lock = pos > 0 ? -mag : mag;
        end
        raw = (lock * longint'(pwr_factor)) / 256;
        r.position = pos[31:0];
        r.axis_report = pos[15:0];
        r.velocity = vel[34:0];
        r.acceleration = acc[44:0];
        r.lock_torque = lock[15:0];
        r.drive_torque = 15'(clip(raw, -longint'(pwr_limit), longint'(pwr_limit)));
        r.torque_changed = raw != prev_raw;
        prev_angle = a;
        prev_velocity = vel;
        prev_raw = raw;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s at %0t: got %0d expected %0d", what, $realtime, got, want);
        mismatches++;
    endtask

    // driver: pops angles off the queue, idles at random between transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (angle_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_angle <= angle_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= $urandom_range(99) >= stall_pct;
        end
    end

    // monitor: predict on each input transfer, check each result transfer
    always @(posedge i_clk) begin
        t_wheel_result w;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_torque(i_angle));
                samples_sent++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_position, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_position !== w.position)
                        report_mismatch("position", o_position, w.position);
                    if (o_axis_report !== w.axis_report)
                        report_mismatch("axis_report", o_axis_report, w.axis_report);
                    if (o_velocity !== w.velocity)
                        report_mismatch("velocity", o_velocity, w.velocity);
                    if (o_acceleration !== w.acceleration)
                        report_mismatch("acceleration", o_acceleration, w.acceleration);
                    if (o_lock_torque !== w.lock_torque)
                        report_mismatch("lock_torque", o_lock_torque, w.lock_torque);
                    if (o_drive_torque !== w.drive_torque)
                        report_mismatch("drive_torque", o_drive_torque, w.drive_torque);
                    if (o_torque_changed !== w.torque_changed)
                        report_mismatch("torque_changed", o_torque_changed, w.torque_changed);
                end
            end
        end
    end

    // watchdog: any transfer resets the count of quiet cycles
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one write transfer, then the channel is left idle
    task automatic write_reg(logic [wast_pkg::CFG_IDX_W-1:0] idx,
                             logic [wast_pkg::CFG_DAT_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_write(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every result, then let the sequencer settle before touching registers
    task automatic drain;
        while (angle_queue.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // angle near either lock boundary with a random offset, near the last angle, or anywhere
    function automatic logic signed [wast_pkg::ANGLE_W-1:0] pick_angle();
        longint edge_pt, v;
        edge_pt = 128 * longint'(deg_range);
        case ($urandom_range(3))
            0: v = longint'($urandom);
            1: v = edge_pt + $urandom_range(3000) - 1500;
            2: v = -edge_pt - $urandom_range(3000) + 1500;
            default: v = longint'($urandom_range(4000)) - 2000 + (prev_angle);
        endcase
        return v[wast_pkg::ANGLE_W-1:0];
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (n) angle_queue.push_back(pick_angle());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config with zero strength, field extremes
        angle_queue.push_back(24'sh7FFFFF);
        angle_queue.push_back(-24'sh800000);
        angle_queue.push_back(24'sd0);
        angle_queue.push_back(24'sh7FFFFF);
        drain();
        // stiff lock, big gain and factor so products saturate
        write_reg(wast_pkg::REG_STRENGTH, 16'd255);
        write_reg(wast_pkg::REG_GAIN, 16'hFFFF);
        write_reg(wast_pkg::REG_POWER_FACT, 16'hFFFF);
        write_reg(wast_pkg::REG_POWER_LIMIT, 16'h3FFF);   // above the nominal 10000
        write_reg(wast_pkg::REG_MAX_DEGREES, 16'h0000);   // ignored
        write_reg(UNUSED_REG, 16'h1234);                  // unused index, no effect
        angle_queue.push_back(24'sh7FFFFF);
        angle_queue.push_back(-24'sh800000);
        angle_queue.push_back(24'sd115200);
        angle_queue.push_back(24'sd115201);
        angle_queue.push_back(-24'sd115201);
        angle_queue.push_back(24'sd116000);
        drain();
        // narrowest and widest range
        write_reg(wast_pkg::REG_MAX_DEGREES, 16'd1);
        write_reg(wast_pkg::REG_POWER_LIMIT, 16'd0);
        angle_queue.push_back(24'sd129);
        angle_queue.push_back(-24'sd129);
        angle_queue.push_back(24'sh7FFFFF);
        drain();
        write_reg(wast_pkg::REG_MAX_DEGREES, 16'h7FFF);
        write_reg(wast_pkg::REG_STRENGTH, 16'd0);
        write_reg(wast_pkg::REG_GAIN, 16'd0);
        write_reg(wast_pkg::REG_POWER_FACT, 16'd0);
        angle_queue.push_back(24'sh7FFFFF);
        angle_queue.push_back(-24'sh800000);
        drain();

        // random phases across settings and idling patterns
        write_reg(wast_pkg::REG_MAX_DEGREES, 16'd900);
        write_reg(wast_pkg::REG_STRENGTH, 16'd40);
        write_reg(wast_pkg::REG_GAIN, 16'd256);
        write_reg(wast_pkg::REG_POWER_FACT, 16'd300);
        write_reg(wast_pkg::REG_POWER_LIMIT, 16'd10000);
        random_phase(200, 0, 0);
        random_phase(200, 73, 0);
        for (int k = 0; k < 5; k++)
            write_reg(k[wast_pkg::CFG_IDX_W-1:0], 16'($urandom));
        random_phase(200, 0, 73);
        write_reg(wast_pkg::REG_MAX_DEGREES, 16'($urandom_range(1, 2000)));
        write_reg(wast_pkg::REG_STRENGTH, 16'($urandom_range(255)));
        write_reg(wast_pkg::REG_GAIN, 16'($urandom_range(1024)));
        write_reg(wast_pkg::REG_POWER_FACT, 16'($urandom_range(1024)));
        write_reg(wast_pkg::REG_POWER_LIMIT, 16'($urandom_range(10000)));
        random_phase(200, 15, 15);

        $display("%0d samples sent, %0d results checked over several register settings",
                 samples_sent, results_seen);
        $display("idle and stall patterns covered, %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
